// ----- rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg - shared types and constants for the first-fit block allocator
// Payload words, configuration bundle, sequencer states and status codes.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 24;

    localparam int OFS_W   = 24;               // heap offsets and sizes
    localparam int ADDR_W  = 32;               // payload addresses
    localparam int GROW_W  = OFS_W + 2;        // break + header + request
    localparam int ENTRY_W = 2 * OFS_W + 1;    // {in_use, start, length}
    localparam int APB_AW  = 3;

    localparam logic       MODE_ALLOC = 1'b0;
    localparam logic       MODE_FREE  = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOMEM   = 2'd1;
    localparam logic [1:0] STAT_ZERO    = 2'd2;
    localparam logic [1:0] STAT_MISSING = 2'd3;

    localparam logic       REG_HEAP_BASE  = 1'b0;
    localparam logic       REG_HEAP_LIMIT = 1'b1;

    localparam logic [OFS_W-1:0] HEAP_LIMIT_RST = '1;

    typedef struct packed {
        logic              mode;
        logic [OFS_W-1:0]  req_size;
        logic [ADDR_W-1:0] free_addr;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0] payload_addr;
        logic [OFS_W-1:0]  granted_size;
        logic [1:0]        status;
    } t_out;

    typedef struct packed {
        logic [ADDR_W-1:0] heap_base;
        logic [OFS_W-1:0]  heap_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_TEST,
        ST_GROW,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/ffba_ram.sv -----
// ----------------------------------------------------------------------------
// ffba_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ffba_cfg.sv -----
// ----------------------------------------------------------------------------
// ffba_cfg - APB configuration registers
// Holds heap base and heap limit; zero-wait writes and reads.
// ----------------------------------------------------------------------------
module ffba_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ffba_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output ffba_pkg::t_cfg             o_cfg
);

    logic [ffba_pkg::ADDR_W-1:0] r_heap_base;
    logic [ffba_pkg::OFS_W-1:0]  r_heap_limit;
    logic                        wr_en;
    logic                        reg_sel;

    assign reg_sel = paddr[2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_heap_limit <= ffba_pkg::HEAP_LIMIT_RST;
        end else if (wr_en) begin
            case (reg_sel)
                ffba_pkg::REG_HEAP_BASE:  r_heap_base  <= pwdata;
                ffba_pkg::REG_HEAP_LIMIT: r_heap_limit <= pwdata[ffba_pkg::OFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            ffba_pkg::REG_HEAP_BASE:  prdata = r_heap_base;
            ffba_pkg::REG_HEAP_LIMIT: prdata = 32'(r_heap_limit);
            default:                  prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = '{heap_base: r_heap_base, heap_limit: r_heap_limit};

endmodule

// ----- rtl/ffba_seq.sv -----
// ----------------------------------------------------------------------------
// ffba_seq - table scan sequencer with shared compare unit
// Walks the block table one entry at a time; appends at the break on an allocate miss.
// ----------------------------------------------------------------------------
module ffba_seq #(
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    localparam int IW = $clog2(MAX_BLOCKS),
    localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  ffba_pkg::t_in                i_item,
    input  ffba_pkg::t_cfg               i_cfg,
    output logic                         o_valid,
    output ffba_pkg::t_out               o_result,
    output logic                         o_ram_we,
    output logic [IW-1:0]                o_ram_waddr,
    output logic [ffba_pkg::ENTRY_W-1:0] o_ram_wdata,
    output logic [IW-1:0]                o_ram_raddr,
    input  logic [ffba_pkg::ENTRY_W-1:0] i_ram_rdata
);

    localparam int OW = ffba_pkg::OFS_W;
    localparam int AW = ffba_pkg::ADDR_W;
    localparam int GW = ffba_pkg::GROW_W;
    localparam logic [AW-1:0] HDR_A = AW'(HEADER_BYTES);
    localparam logic [GW-1:0] HDR_G = GW'(HEADER_BYTES);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);

    ffba_pkg::t_state r_state, n_state;

    // control state
    logic [CW-1:0] r_count, n_count;
    logic [OW-1:0] r_break, n_break;

    // working registers
    logic          r_mode,   n_mode;
    logic [OW-1:0] r_req,    n_req;
    logic [AW-1:0] r_key,    n_key;      // free address as a heap offset
    logic [AW-1:0] r_base_h, n_base_h;   // heap_base + header
    logic [IW-1:0] r_idx,    n_idx;
    logic [AW-1:0] r_addr,   n_addr;
    logic [OW-1:0] r_size,   n_size;
    logic [1:0]    r_status, n_status;

    logic          rd_used;
    logic [OW-1:0] rd_start;
    logic [OW-1:0] rd_len;
    logic [AW-1:0] cmp_a, cmp_b;
    logic          cmp_ge, cmp_eq;
    logic          hit, last, zero_req;
    logic [GW-1:0] grow_sum;
    logic          grow_ok;

    assign rd_used  = i_ram_rdata[ffba_pkg::ENTRY_W-1];
    assign rd_start = i_ram_rdata[2*OW-1:OW];
    assign rd_len   = i_ram_rdata[OW-1:0];

    // shared compare: size fit on allocate, offset match on free
    assign cmp_a  = (r_mode == ffba_pkg::MODE_ALLOC) ? AW'(rd_len) : AW'(rd_start);
    assign cmp_b  = (r_mode == ffba_pkg::MODE_ALLOC) ? AW'(r_req)  : r_key;
    assign cmp_ge = (cmp_a >= cmp_b);
    assign cmp_eq = (cmp_a == cmp_b);
    assign hit    = (r_mode == ffba_pkg::MODE_ALLOC) ? (!rd_used && cmp_ge) : cmp_eq;
    assign last   = ((CW'(r_idx) + CW'(1)) == r_count);

    assign zero_req = (i_item.mode == ffba_pkg::MODE_ALLOC) ? (i_item.req_size == '0)
                                                            : (i_item.free_addr == '0);

    assign grow_sum = GW'(r_break) + HDR_G + GW'(r_req);
    assign grow_ok  = (r_count < MAX_C) && (grow_sum <= GW'(i_cfg.heap_limit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::ST_IDLE;
            r_count <= '0;
            r_break <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_break <= n_break;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_req    <= n_req;
        r_key    <= n_key;
        r_base_h <= n_base_h;
        r_idx    <= n_idx;
        r_addr   <= n_addr;
        r_size   <= n_size;
        r_status <= n_status;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffba_pkg::ST_IDLE: begin
                if (start) begin
                    if (zero_req) begin
                        n_state = ffba_pkg::ST_DONE;
                    end else if (r_count == '0) begin
                        n_state = (i_item.mode == ffba_pkg::MODE_ALLOC) ? ffba_pkg::ST_GROW
                                                                        : ffba_pkg::ST_DONE;
                    end else begin
                        n_state = ffba_pkg::ST_FETCH;
                    end
                end
            end
            ffba_pkg::ST_FETCH: n_state = ffba_pkg::ST_TEST;
            ffba_pkg::ST_TEST: begin
                if (hit) begin
                    n_state = ffba_pkg::ST_DONE;
                end else if (last) begin
                    n_state = (r_mode == ffba_pkg::MODE_ALLOC) ? ffba_pkg::ST_GROW
                                                               : ffba_pkg::ST_DONE;
                end else begin
                    n_state = ffba_pkg::ST_FETCH;
                end
            end
            ffba_pkg::ST_GROW: n_state = ffba_pkg::ST_DONE;
            ffba_pkg::ST_DONE: n_state = ffba_pkg::ST_IDLE;
            default:           n_state = ffba_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_count  = r_count;
        n_break  = r_break;
        n_mode   = r_mode;
        n_req    = r_req;
        n_key    = r_key;
        n_base_h = r_base_h;
        n_idx    = r_idx;
        n_addr   = r_addr;
        n_size   = r_size;
        n_status = r_status;
        case (r_state)
            ffba_pkg::ST_IDLE: begin
                if (start) begin
                    n_mode   = i_item.mode;
                    n_req    = i_item.req_size;
                    n_key    = i_item.free_addr - i_cfg.heap_base - HDR_A;
                    n_base_h = i_cfg.heap_base + HDR_A;
                    n_idx    = '0;
                    n_addr   = '0;
                    n_size   = '0;
                    n_status = zero_req ? ffba_pkg::STAT_ZERO : ffba_pkg::STAT_MISSING;
                end
            end
            ffba_pkg::ST_TEST: begin
                if (hit) begin
                    n_status = ffba_pkg::STAT_OK;
                    if (r_mode == ffba_pkg::MODE_ALLOC) begin
                        n_addr = r_base_h + AW'(rd_start);
                        n_size = rd_len;
                    end
                end else if (!last) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ffba_pkg::ST_GROW: begin
                if (grow_ok) begin
                    n_status = ffba_pkg::STAT_OK;
                    n_addr   = r_base_h + AW'(r_break);
                    n_size   = r_req;
                    n_count  = r_count + CW'(1);
                    n_break  = grow_sum[OW-1:0];
                end else begin
                    n_status = ffba_pkg::STAT_NOMEM;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        busy        = (r_state != ffba_pkg::ST_IDLE);
        o_valid     = (r_state == ffba_pkg::ST_DONE);
        o_ram_raddr = r_idx;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx;
        o_ram_wdata = {(r_mode == ffba_pkg::MODE_ALLOC), rd_start, rd_len};
        case (r_state)
            ffba_pkg::ST_TEST: o_ram_we = hit;
            ffba_pkg::ST_GROW: begin
                o_ram_we    = grow_ok;
                o_ram_waddr = r_count[IW-1:0];
                o_ram_wdata = {1'b1, r_break, r_req};
            end
            default: ;
        endcase
    end

    assign o_result = '{payload_addr: r_addr, granted_size: r_size, status: r_status};

endmodule

// ----- rtl/first_fit_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top - first-fit heap block allocator
// Null or zero-size requests go straight to the result; otherwise each entry visited
// takes a fetch and a test step, plus a grow step when a new block is appended.
// Throughput: one word at a time; busy stays high through the result strobe cycle.
// The scan reads the table through the single read port of the block table RAM.
// Result is shown for exactly one cycle with o_valid; the receiver cannot stall.
// Reset (synchronous, i_rst_n low) empties the table and zeroes the break.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top #(
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        start,
    output logic                        busy,
    input  ffba_pkg::t_in               i_item,
    // result channel
    output logic                        o_valid,
    output ffba_pkg::t_out              o_result,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffba_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IW = $clog2(MAX_BLOCKS);

    ffba_pkg::t_cfg               cfg;
    logic                         ram_we;
    logic [IW-1:0]                ram_waddr;
    logic [ffba_pkg::ENTRY_W-1:0] ram_wdata;
    logic [IW-1:0]                ram_raddr;
    logic [ffba_pkg::ENTRY_W-1:0] ram_rdata;

    // heap base / limit registers
    ffba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // block table: {in_use, start, length} per entry. Only entries below the
    // block count are ever read, so the RAM needs no clearing after reset.
    ffba_ram #(
        .WIDTH (ffba_pkg::ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // scan sequencer: fetch, test with the shared comparator, append on a miss
    ffba_seq #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg       (cfg),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

endmodule

// ----- bench/first_fit_block_allocator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top_tb - self-checking bench for the heap allocator
// Directed table, then random allocate/free traffic over several heap_base and
// heap_limit settings. Results are checked against typed words or a local model.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top_tb;

    localparam int MAXB = ffba_pkg::MAX_BLOCKS_DEF;
    localparam int HDR  = ffba_pkg::HEADER_BYTES_DEF;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int PHASES = 5;
    localparam logic CHK  = 1'b1;   // expected word typed into the row
    localparam logic PRED = 1'b0;   // expected word comes from the model

    // directed row: command word, typed flag, expected result word
    typedef struct packed {
        ffba_pkg::t_in  word;
        logic           chk;
        ffba_pkg::t_out want;
    } t_row;

    // Reset config: heap_base 0, heap_limit all ones, empty table, break at 0.
    localparam int N_ROWS = 19;
    localparam t_row DIR_ROWS [N_ROWS] = '{
        {ffba_pkg::MODE_ALLOC, 24'd0,       32'd0,         CHK,  32'd0,  24'd0,
         ffba_pkg::STAT_ZERO},
        {ffba_pkg::MODE_FREE,  24'd0,       32'd0,         CHK,  32'd0,  24'd0,
         ffba_pkg::STAT_ZERO},
        {ffba_pkg::MODE_FREE,  24'd0,       32'hFFFF_FFFF, CHK,  32'd0,  24'd0,
         ffba_pkg::STAT_MISSING},
        {ffba_pkg::MODE_ALLOC, 24'hFF_FFFF, 32'd0,         CHK,  32'd0,  24'd0,
         ffba_pkg::STAT_NOMEM},
        {ffba_pkg::MODE_ALLOC, 24'd1,       32'd0,         CHK,  32'd24, 24'd1,
         ffba_pkg::STAT_OK},
        {ffba_pkg::MODE_ALLOC, 24'hFF_FFCF, 32'd0,         PRED, 32'd0,  24'd0,
         ffba_pkg::STAT_OK},
        {ffba_pkg::MODE_ALLOC, 24'd100,     32'hFFFF_FFFF, PRED, 32'd0,  24'd0,
         ffba_pkg::STAT_OK},
        {ffba_pkg::MODE_FREE,  24'hFF_FFFF, 32'd24,        CHK,  32'd0,  24'd0,
         ffba_pkg::STAT_OK},
        {ffba_pkg::MODE_FREE,  24'd0,       32'd24,        CHK,  32'd0,  24'd0,
         ffba_pkg::STAT_OK},
        {ffba_pkg::MODE_ALLOC, 24'd2,       32'd0,         PRED, 32'd0,  24'd0,
         ffba_pkg::STAT_OK},
        {ffba_pkg::MODE_ALLOC, 24'd1,       32'd0,         CHK,  32'd24, 24'd1,
         ffba_pkg::STAT_OK},
        {ffba_pkg::MODE_FREE,  24'd0,       32'd49,        CHK,  32'd0,  24'd0,
         ffba_pkg::STAT_OK},
        {ffba_pkg::MODE_ALLOC, 24'd50,      32'd0,         PRED, 32'd0,  24'd0,
         ffba_pkg::STAT_OK},
        {ffba_pkg::MODE_FREE,  24'd0,       32'd25,        CHK,  32'd0,  24'd0,
         ffba_pkg::STAT_MISSING},
        {ffba_pkg::MODE_FREE,  24'd0,       32'h8000_0000, CHK,  32'd0,  24'd0,
         ffba_pkg::STAT_MISSING},
        {ffba_pkg::MODE_FREE,  24'd0,       32'd49,        CHK,  32'd0,  24'd0,
         ffba_pkg::STAT_OK},
        {ffba_pkg::MODE_ALLOC, 24'd101,     32'd0,         PRED, 32'd0,  24'd0,
         ffba_pkg::STAT_OK},
        {ffba_pkg::MODE_FREE,  24'd0,       32'd173,       CHK,  32'd0,  24'd0,
         ffba_pkg::STAT_OK},
        {ffba_pkg::MODE_ALLOC, 24'd2,       32'd0,         PRED, 32'd0,  24'd0,
         ffba_pkg::STAT_OK}
    };

    // ------------------------------------------------------------------------
    // DUT connections; every input known from time zero
    // ------------------------------------------------------------------------
    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start   = 1'b0;
    logic                        busy;
    ffba_pkg::t_in               i_item  = '0;
    logic                        o_valid;
    ffba_pkg::t_out              o_result;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [ffba_pkg::APB_AW-1:0] paddr   = '0;
    logic [31:0]                 pwdata  = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    first_fit_block_allocator_top #(
        .MAX_BLOCKS   (MAXB),
        .HEADER_BYTES (HDR)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Heap model: its own copy of the table, the break and the registers
    // ------------------------------------------------------------------------
    logic [ffba_pkg::OFS_W-1:0]  blk_start [MAXB];
    logic [ffba_pkg::OFS_W-1:0]  blk_len   [MAXB];
    logic                        blk_used  [MAXB];
    int                          blk_count = 0;
    logic [ffba_pkg::OFS_W-1:0]  heap_brk  = '0;
    logic [ffba_pkg::ADDR_W-1:0] heap_base_q  = '0;
    logic [ffba_pkg::OFS_W-1:0]  heap_limit_q = ffba_pkg::HEAP_LIMIT_RST;

    ffba_pkg::t_out expected_grants [$];   // result words still owed by the DUT
    int             mismatches = 0;

    // payload address of a table entry, wraps at 32 bits
    function automatic logic [ffba_pkg::ADDR_W-1:0] payload_at(input int idx);
        return heap_base_q + 32'(blk_start[idx]) + 32'(HDR);
    endfunction

    // Applies one command to the model and returns the word the DUT must give.
    task automatic predict_heap_op(input ffba_pkg::t_in w, output ffba_pkg::t_out r);
        logic [ffba_pkg::GROW_W-1:0] grow;
        int hit;
        hit = -1;
        r   = '0;
        if (w.mode == ffba_pkg::MODE_ALLOC) begin
            if (w.req_size == '0) begin
                r.status = ffba_pkg::STAT_ZERO;
            end else begin
                // first fit, no split
                for (int i = 0; i < blk_count; i++) begin
                    if (hit < 0 && !blk_used[i] && blk_len[i] >= w.req_size)
                        hit = i;
                end
                grow = ffba_pkg::GROW_W'(heap_brk) + ffba_pkg::GROW_W'(HDR)
                     + ffba_pkg::GROW_W'(w.req_size);
                if (hit >= 0) begin
                    blk_used[hit]  = 1'b1;
                    r.payload_addr = payload_at(hit);
                    r.granted_size = blk_len[hit];
                    r.status       = ffba_pkg::STAT_OK;
                end else if (blk_count >= MAXB
                             || grow > ffba_pkg::GROW_W'(heap_limit_q)) begin
                    r.status = ffba_pkg::STAT_NOMEM;
                end else begin
                    // append a fresh block at the break
                    blk_start[blk_count] = heap_brk;
                    blk_len[blk_count]   = w.req_size;
                    blk_used[blk_count]  = 1'b1;
                    r.payload_addr = payload_at(blk_count);
                    r.granted_size = w.req_size;
                    r.status       = ffba_pkg::STAT_OK;
                    blk_count++;
                    heap_brk = grow[ffba_pkg::OFS_W-1:0];
                end
            end
        end else begin
            if (w.free_addr == '0) begin
                r.status = ffba_pkg::STAT_ZERO;
            end else begin
                for (int i = 0; i < blk_count; i++) begin
                    if (hit < 0 && payload_at(i) == w.free_addr)
                        hit = i;
                end
                if (hit >= 0) begin
                    blk_used[hit] = 1'b0;   // freeing a free block is still ok
                    r.status = ffba_pkg::STAT_OK;
                end else begin
                    r.status = ffba_pkg::STAT_MISSING;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Command side: word held on i_item with start high until busy is low
    // ------------------------------------------------------------------------
    task automatic send_word(input ffba_pkg::t_in w, input logic typed,
                             input ffba_pkg::t_out typed_want);
        ffba_pkg::t_out r;
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        predict_heap_op(w, r);
        expected_grants.push_back(typed ? typed_want : r);
    endtask

    task automatic idle_gap(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain;
        while (expected_grants.size() != 0) @(posedge i_clk);
    endtask

    // APB write, then read back; model register updated at the write edge
    task automatic cfg_write_check(input logic idx, input logic [31:0] val);
        logic [31:0] got;
        logic [31:0] want;
        logic [31:0] keep;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == ffba_pkg::REG_HEAP_BASE) heap_base_q  = val;
        else                                heap_limit_q = val[ffba_pkg::OFS_W-1:0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        keep = (idx == ffba_pkg::REG_HEAP_BASE) ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
        want = (idx == ffba_pkg::REG_HEAP_BASE) ? heap_base_q : 32'(heap_limit_q);
        if ((got & keep) !== want) begin
            $display("%0t: readback reg %0d expected %h got %h", $time, idx, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result check: one word per o_valid cycle, oldest expectation first
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        ffba_pkg::t_out want;
        if (i_rst_n && o_valid) begin
            if (expected_grants.size() == 0) begin
                $display("%0t: result word with nothing pending, got %h", $time, o_result);
                mismatches++;
            end else begin
                want = expected_grants.pop_front();
                if (o_result.payload_addr !== want.payload_addr) begin
                    $display("%0t: payload_addr expected %h got %h", $time,
                             want.payload_addr, o_result.payload_addr);
                    mismatches++;
                end
                if (o_result.granted_size !== want.granted_size) begin
                    $display("%0t: granted_size expected %h got %h", $time,
                             want.granted_size, o_result.granted_size);
                    mismatches++;
                end
                if (o_result.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time,
                             want.status, o_result.status);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        ffba_pkg::t_in w;
        int  roll;
        int  burst_left;
        int  fit;
        int  gap;
        burst_left = 0;
        foreach (blk_used[i]) begin
            blk_start[i] = '0;
            blk_len[i]   = '0;
            blk_used[i]  = 1'b0;
        end

        // synchronous reset, only once
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with reset register values. Covers zero size, null
        // free, unknown address, refusal past the limit, exact-size append,
        // reuse of a larger free block and a double free.
        for (int k = 0; k < N_ROWS; k++) begin
            send_word(DIR_ROWS[k].word, DIR_ROWS[k].chk, DIR_ROWS[k].want);
            gap = $urandom_range(0, 3);
            if (gap != 0) idle_gap(gap);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            // registers only move while the allocator is idle
            idle_gap(0);
            drain();
            case (phase)
                0: begin
                    // tight limit just above the break: boundary appends
                    cfg_write_check(ffba_pkg::REG_HEAP_BASE, $urandom);
                    fit = int'(heap_brk) + int'($urandom_range(200, 4000));
                    cfg_write_check(ffba_pkg::REG_HEAP_LIMIT,
                                    (fit > 32'hFF_FFFF) ? 32'hFF_FFFF : 32'(fit));
                end
                1: begin
                    // payload addresses wrap through zero, full heap
                    cfg_write_check(ffba_pkg::REG_HEAP_BASE, 32'hFFFF_FFF0);
                    cfg_write_check(ffba_pkg::REG_HEAP_LIMIT, 32'hFFFF_FFFF);
                end
                2: begin
                    // limit below the break: every append is refused
                    cfg_write_check(ffba_pkg::REG_HEAP_BASE, 32'h8000_0000);
                    cfg_write_check(ffba_pkg::REG_HEAP_LIMIT, 32'h0);
                end
                3: begin
                    cfg_write_check(ffba_pkg::REG_HEAP_BASE, $urandom);
                    cfg_write_check(ffba_pkg::REG_HEAP_LIMIT, $urandom);
                end
                default: begin
                    cfg_write_check(ffba_pkg::REG_HEAP_BASE, 32'h0);
                    cfg_write_check(ffba_pkg::REG_HEAP_LIMIT, 32'h00FF_FFFF);
                end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // bursts with gaps long enough to land on any scan step
                if (burst_left == 0) begin
                    roll = $urandom_range(0, 99);
                    if (roll >= 30) begin
                        gap = (roll < 80) ? $urandom_range(1, 8) : $urandom_range(9, 140);
                        idle_gap(gap);
                    end
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;

                // ignored field gets noise as well
                w.req_size  = ffba_pkg::OFS_W'($urandom);
                w.free_addr = $urandom;
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    w.mode     = ffba_pkg::MODE_ALLOC;
                    w.req_size = ($urandom_range(0, 3) != 0)
                               ? ffba_pkg::OFS_W'($urandom_range(1, 64))
                               : ffba_pkg::OFS_W'($urandom_range(1, 4096));
                end else if (roll < 80) begin
                    // release a live block, now and then one already free
                    w.mode = ffba_pkg::MODE_FREE;
                    if (blk_count > 0)
                        w.free_addr = payload_at($urandom_range(0, blk_count - 1));
                end else if (roll < 87) begin
                    // full-width sizes only where they cannot eat the heap
                    w.mode = ffba_pkg::MODE_ALLOC;
                    if (!(blk_count == MAXB || phase == 0 || phase == 2))
                        w.req_size = ffba_pkg::OFS_W'($urandom_range(1, 4096));
                end else if (roll < 92) begin
                    w.mode = ffba_pkg::MODE_FREE;
                end else if (roll < 96) begin
                    w.mode = roll[0] ? ffba_pkg::MODE_FREE : ffba_pkg::MODE_ALLOC;
                    if (w.mode == ffba_pkg::MODE_ALLOC) w.req_size  = '0;
                    else                                w.free_addr = '0;
                end else begin
                    // exact fit to the limit, or one byte over
                    w.mode = ffba_pkg::MODE_ALLOC;
                    fit = int'(heap_limit_q) - int'(heap_brk) - HDR;
                    w.req_size = (fit >= 1)
                               ? ffba_pkg::OFS_W'(fit + int'($urandom_range(0, 1)))
                               : ffba_pkg::OFS_W'($urandom_range(1, 64));
                end
                send_word(w, 1'b0, '0);
            end
        end

        // all sent; wait out the tail and watch for stray words
        idle_gap(0);
        drain();
        repeat (2 * MAXB + 8) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hard stop, several times the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
